/* rtl/core/min_heap_build_defines.svh */
// Assertion macros for the min-heap build block.
// Included by the top level; depends on nothing else.
`ifndef MIN_HEAP_BUILD_DEFINES_SVH
`define MIN_HEAP_BUILD_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MHB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MHB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mhb_pkg.sv */
// Shared constants and types of the min-heap build block.
// Used by the engine and the top level; depends on nothing.
package mhb_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W       = 32;
  localparam int INDEX_W      = 6;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  // Child positions 2*i+1 and 2*i+2 need one bit above the address plus headroom.
  localparam int CHILD_W      = ADDR_W + 2;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ELEMENTS);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] heap_value;
    logic [INDEX_W-1:0]       heap_index;
    logic                     last_result;
    logic                     overflowed;
  } result_t;

  // Load request from the engine into the output register.
  typedef struct packed {
    logic    load;
    result_t result;
  } emit_t;

  // Port requests from the engine to the element memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

/* rtl/core/mhb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/mhb_engine.sv */
// Sequencer of the min-heap build: load, Floyd sift-down and emission.
// Depends on mhb_pkg; drives the ports of the element memory.
module mhb_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  mhb_pkg::item_t                 item,
  input  logic                           out_free,
  output mhb_pkg::emit_t                 emit,
  output mhb_pkg::ram_req_t              ram_req,
  input  logic [mhb_pkg::DATA_W-1:0]     ram_rdata
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PARENT,
    S_CUR,
    S_CHILD,
    S_LEFT,
    S_RIGHT,
    S_EREAD,
    S_EOUT
  } state_t;

  state_t                           state;
  logic [mhb_pkg::CNT_W-1:0]        count;
  logic                             ovf;
  logic [mhb_pkg::ADDR_W-1:0]       parent;
  logic [mhb_pkg::ADDR_W-1:0]       pos;
  logic [mhb_pkg::ADDR_W-1:0]       k;
  logic signed [mhb_pkg::DATA_W-1:0] cur;
  logic signed [mhb_pkg::DATA_W-1:0] lval;

  logic signed [mhb_pkg::DATA_W-1:0] rd;
  logic [mhb_pkg::CHILD_W-1:0]      left;
  logic [mhb_pkg::CHILD_W-1:0]      right;
  logic [mhb_pkg::CHILD_W-1:0]      count_ext;
  logic                             has_left;
  logic                             has_right;
  logic                             has_room;
  logic [mhb_pkg::CNT_W-1:0]        cnt_after;
  logic                             right_win;
  logic [mhb_pkg::CHILD_W-1:0]      best;
  logic signed [mhb_pkg::DATA_W-1:0] best_val;
  logic                             emit_last;

  assign rd        = $signed(ram_rdata);
  assign left      = {1'b0, pos, 1'b1};
  assign right     = left + mhb_pkg::CHILD_W'(1);
  assign count_ext = mhb_pkg::CHILD_W'(count);
  assign has_left  = left < count_ext;
  assign has_right = right < count_ext;
  assign has_room  = count < mhb_pkg::MAX_COUNT;
  assign cnt_after = has_room ? count + mhb_pkg::CNT_W'(1) : count;
  // The left child wins a tie between the children.
  assign right_win = rd < lval;
  assign best      = right_win ? right : left;
  assign best_val  = right_win ? rd : lval;
  assign emit_last = (mhb_pkg::CNT_W'(k) + mhb_pkg::CNT_W'(1)) == count;

  assign item_ready = (state == S_LOAD);

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = pos;
    ram_req.wdata = cur;
    ram_req.raddr = pos;
    emit.load                = 1'b0;
    emit.result.heap_value   = rd;
    emit.result.heap_index   = mhb_pkg::INDEX_W'(k);
    emit.result.last_result  = emit_last;
    emit.result.overflowed   = ovf;
    unique case (state)
      S_LOAD: begin
        if (item_valid && has_room) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = count[mhb_pkg::ADDR_W-1:0];
          ram_req.wdata = item.value;
        end
      end
      S_PARENT: ram_req.raddr = parent;
      S_CUR: ;
      S_CHILD: begin
        if (has_left) begin
          ram_req.raddr = left[mhb_pkg::ADDR_W-1:0];
        end else begin
          ram_req.we = 1'b1;
        end
      end
      S_LEFT: begin
        if (has_right) begin
          ram_req.raddr = right[mhb_pkg::ADDR_W-1:0];
        end else begin
          ram_req.we = 1'b1;
          if (rd < cur) begin
            ram_req.wdata = rd;
          end
        end
      end
      S_RIGHT: begin
        ram_req.we = 1'b1;
        if (best_val < cur) begin
          ram_req.wdata = best_val;
        end
      end
      S_EREAD: ram_req.raddr = k;
      S_EOUT:  emit.load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      count  <= '0;
      ovf    <= 1'b0;
      parent <= '0;
      pos    <= '0;
      k      <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (item_valid) begin
            count <= cnt_after;
            if (!has_room) begin
              ovf <= 1'b1;
            end
            if (item.last_value) begin
              k <= '0;
              if (cnt_after < mhb_pkg::CNT_W'(2)) begin
                state <= S_EREAD;
              end else begin
                parent <= mhb_pkg::ADDR_W'((cnt_after >> 1) - mhb_pkg::CNT_W'(1));
                pos    <= mhb_pkg::ADDR_W'((cnt_after >> 1) - mhb_pkg::CNT_W'(1));
                state  <= S_PARENT;
              end
            end
          end
        end
        S_PARENT: state <= S_CUR;
        S_CUR: begin
          cur   <= rd;
          state <= S_CHILD;
        end
        S_CHILD: begin
          if (has_left) begin
            state <= S_LEFT;
          end else if (parent == '0) begin
            state <= S_EREAD;
          end else begin
            parent <= parent - mhb_pkg::ADDR_W'(1);
            pos    <= parent - mhb_pkg::ADDR_W'(1);
            state  <= S_PARENT;
          end
        end
        S_LEFT: begin
          lval <= rd;
          if (has_right) begin
            state <= S_RIGHT;
          end else if (rd < cur) begin
            pos   <= left[mhb_pkg::ADDR_W-1:0];
            state <= S_CHILD;
          end else if (parent == '0) begin
            state <= S_EREAD;
          end else begin
            parent <= parent - mhb_pkg::ADDR_W'(1);
            pos    <= parent - mhb_pkg::ADDR_W'(1);
            state  <= S_PARENT;
          end
        end
        S_RIGHT: begin
          if (best_val < cur) begin
            pos   <= best[mhb_pkg::ADDR_W-1:0];
            state <= S_CHILD;
          end else if (parent == '0) begin
            state <= S_EREAD;
          end else begin
            parent <= parent - mhb_pkg::ADDR_W'(1);
            pos    <= parent - mhb_pkg::ADDR_W'(1);
            state  <= S_PARENT;
          end
        end
        S_EREAD: begin
          // The read is issued only once the output register will be empty.
          if (out_free) begin
            state <= S_EOUT;
          end
        end
        S_EOUT: begin
          if (emit_last) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end else begin
            k     <= k + mhb_pkg::ADDR_W'(1);
            state <= S_EREAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

/* rtl/core/min_heap_build.sv */
// Top level of the min-heap build block: engine, element memory, output register.
// Depends on mhb_pkg, mhb_ram, mhb_engine and min_heap_build_defines.svh.
//
//   channel  direction  handshake                payload
//   item     in         item_valid / item_ready  mhb_pkg::item_t
//   heap     out        heap_valid / heap_ready  mhb_pkg::result_t
//
// Loading takes one element per cycle. After the marked element the block builds the
// heap: S_PARENT and S_CUR fetch each parent, then per level S_CHILD, S_LEFT and S_RIGHT
// read the children and compare, skipping states for missing children (one read port).
// Each result is read in S_EREAD, held until the output frees, and loaded in S_EOUT.
// Nothing is taken after the marked element until the last result is loaded for output.
// Reset (rst, synchronous) empties the load and the output register.
`include "min_heap_build_defines.svh"

module min_heap_build (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  mhb_pkg::item_t   item,
  output logic             heap_valid,
  input  logic             heap_ready,
  output mhb_pkg::result_t heap
);

  mhb_pkg::emit_t                emit;
  mhb_pkg::ram_req_t             ram_req;
  logic [mhb_pkg::DATA_W-1:0]    ram_rdata;
  logic                          out_free;

  assign out_free = !heap_valid || heap_ready;

  mhb_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_free   (out_free),
    .emit       (emit),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  mhb_ram #(
    .WIDTH (mhb_pkg::DATA_W),
    .DEPTH (mhb_pkg::MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_valid <= 1'b0;
    end else if (emit.load) begin
      heap_valid <= 1'b1;
    end else if (heap_ready) begin
      heap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      heap <= emit.result;
    end
  end

  `MHB_ASSERT_IMP(a_load_into_free, clk, rst, emit.load, !heap_valid, "result loaded over a pending one")
  `MHB_ASSERT_NXT(a_busy_while_emitting, clk, rst, heap_valid && heap_ready && !heap.last_result, !item_ready, "input taken during emission")
  `MHB_ASSERT_NXT(a_load_after_last, clk, rst, emit.load && emit.result.last_result, item_ready, "no return to loading after the final result")

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for min_heap_build: loads of signed elements go in, and every
// heap entry that comes out is compared with a heap built here from the accepted elements.
// Depends on mhb_pkg and the min_heap_build RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mhb_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    heap_valid;
  logic    heap_ready = 1'b0;
  result_t heap;

  min_heap_build u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .heap_valid (heap_valid),
    .heap_ready (heap_ready),
    .heap       (heap)
  );

  always #5 clk = ~clk;

  logic signed [DATA_W-1:0] load_elems[$];   // elements held by the current load
  logic                     load_dropped;    // an element of this load did not fit
  logic signed [DATA_W-1:0] load_plan[$];    // values of the next load to send
  result_t                  heap_expect_q[$];

  int  error_count     = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  loads_done      = 0;
  int  stall_cycles    = 0;
  int  ready_hold      = 0;
  bit  idle_enable     = 1'b1;

  initial load_dropped = 1'b0;

  function automatic int pick_gap();
    int r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return $signed(DATA_W'($urandom_range(0, 6))) - 3;
    if (r == 8) return VAL_MAX - $urandom_range(0, 1);
    return VAL_MIN + $urandom_range(0, 1);
  endfunction

  // Track one accepted element; the marked one builds the heap and queues every entry.
  function automatic void heap_predict(logic signed [DATA_W-1:0] v, logic lst);
    logic signed [DATA_W-1:0] h[MAX_ELEMENTS];
    logic signed [DATA_W-1:0] tmp;
    result_t r;
    int n, pos, least, lc, rc;
    bit settled;
    if (load_elems.size() < MAX_ELEMENTS) load_elems.push_back(v);
    else load_dropped = 1'b1;
    if (!lst) return;
    n = load_elems.size();
    for (int i = 0; i < n; i++) h[i] = load_elems[i];
    for (int p = n / 2 - 1; p >= 0; p--) begin
      pos = p;
      settled = 1'b0;
      while (!settled) begin
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        least = pos;
        // The left child wins a tie because only a strictly smaller value moves least.
        if (lc < n && h[lc] < h[least]) least = lc;
        if (rc < n && h[rc] < h[least]) least = rc;
        if (least == pos) begin
          settled = 1'b1;
        end else begin
          tmp = h[pos];
          h[pos] = h[least];
          h[least] = tmp;
          pos = least;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      r.heap_value  = h[k];
      r.heap_index  = INDEX_W'(k);
      r.last_result = (k == n - 1);
      r.overflowed  = load_dropped;
      heap_expect_q.push_back(r);
    end
    load_elems.delete();
    load_dropped = 1'b0;
    loads_done++;
  endfunction

  function automatic void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                        logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Result checker and watchdog, both sampled at the rising edge.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if ((item_valid && item_ready) || (heap_valid && heap_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d heap entries outstanding",
                 $time, heap_expect_q.size());
        $display("DONE: errors detected");
        $finish;
      end
      if (heap_valid && heap_ready) begin
        if (heap_expect_q.size() == 0) begin
          $display("%0t: unexpected heap entry: expected none, actual value %0d index %0d",
                   $time, heap.heap_value, heap.heap_index);
          error_count++;
        end else begin
          exp_r = heap_expect_q.pop_front();
          compare_field("heap_value", exp_r.heap_value, heap.heap_value);
          compare_field("heap_index", DATA_W'(exp_r.heap_index), DATA_W'(heap.heap_index));
          compare_field("last_result", DATA_W'(exp_r.last_result), DATA_W'(heap.last_result));
          compare_field("overflowed", DATA_W'(exp_r.overflowed), DATA_W'(heap.overflowed));
          results_checked++;
        end
      end
    end
  end

  // Receiver: ready drops for random stretches.
  always @(negedge clk) begin
    if (rst) begin
      heap_ready = 1'b0;
    end else if (ready_hold > 0) begin
      heap_ready = 1'b0;
      ready_hold--;
    end else begin
      heap_ready = 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer with valid low,
  // so a following call with no gap raises it again in the same time step.
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid      = 1'b1;
    item.value      = v;
    item.last_value = lst;
    do @(posedge clk); while (!item_ready);
    heap_predict(v, lst);
    items_sent++;
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  task automatic send_planned_load();
    for (int i = 0; i < load_plan.size(); i++) send_item(load_plan[i], i == load_plan.size() - 1);
    load_plan.delete();
  endtask

  task automatic wait_drained();
    while (heap_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_single_element();
    load_plan = '{VAL_MIN};
    send_planned_load();
    load_plan = '{VAL_MAX};
    send_planned_load();
  endtask

  task automatic test_extreme_values();
    load_plan = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN, VAL_MAX};
    send_planned_load();
  endtask

  task automatic test_child_ties();
    load_plan = '{9, 4, 4, 4, 2, 2};
    send_planned_load();
  endtask

  task automatic test_descending();
    load_plan = '{8, 7, 6, 5, 4, 3, 2, 1};
    send_planned_load();
  endtask

  task automatic test_random_loads();
    int n, sent;
    sent = 0;
    while (sent < 18) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      // Some loads go through back to back with no idle cycles at all.
      idle_enable = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n; i++) load_plan.push_back(rand_value());
      send_planned_load();
      sent += n;
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_overflow();
    int extra;
    extra = $urandom_range(1, 2);
    // Fill the store, then push past it; the marked element is one of the dropped ones.
    for (int i = 0; i < MAX_ELEMENTS + extra; i++) load_plan.push_back(rand_value());
    send_planned_load();
    wait_drained();
    // The flag belongs to one load only.
    for (int i = 0; i < 3; i++) load_plan.push_back(rand_value());
    send_planned_load();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_single_element();
    test_extreme_values();
    test_child_ties();
    test_descending();
    wait_drained();
    test_random_loads();
    test_overflow();
    @(negedge clk);
    item_valid = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk);
    $display("Sent %0d elements in %0d loads and checked %0d heap entries,", items_sent,
             loads_done, results_checked);
    $display("covering single, tied, extreme, random and overflowing loads under stalls.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
